/* rtl/kpg_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kpg_pkg: shared definitions for the k-permutation generator
// Widths, register codes, cell control types and the helper functions used
// by the digit cells and the sequencer.
// ----------------------------------------------------------------------------
package kpg_pkg;

    // Field and storage widths.
    localparam int DIGIT_W        = 4;
    localparam int MASK_W         = 16;
    localparam int SEL_NIBBLES    = 9;
    localparam int SEL_W          = 36;
    localparam int CFG_IDX_W      = 4;
    localparam int CFG_DATA_W     = 4;
    localparam int DEF_MAX_DIGITS = 9;

    // Register reset values.
    localparam logic [CFG_DATA_W-1:0] RST_SYMBOL_COUNT = 4'd9;
    localparam logic [CFG_DATA_W-1:0] RST_PICK_COUNT   = 4'd3;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SYMBOL_COUNT = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PICK_COUNT   = 4'd1;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_FILL
    } kpg_state_t;

    // Per-cell control from the sequencer.
    typedef struct packed {
        logic restart;
        logic pivot_we;
        logic fill_we;
    } kpg_cell_ctrl_t;

    // Per-cell status back to the sequencer.
    typedef struct packed {
        logic               can_inc;
        logic [DIGIT_W-1:0] digit;
    } kpg_cell_stat_t;

    // Smallest symbol above lower and not above n that is not in used.
    // The top bit of the result flags that such a symbol exists.
    function automatic logic [DIGIT_W:0] next_free(
        input logic [MASK_W-1:0]  used,
        input logic [DIGIT_W-1:0] lower,
        input logic [DIGIT_W-1:0] n
    );
        logic               found;
        logic [DIGIT_W-1:0] val;
        found = 1'b0;
        val   = '0;
        for (int v = MASK_W - 1; v >= 1; v--)
        begin
            if ((v > lower) && (v <= n) && !used[v])
            begin
                found = 1'b1;
                val   = DIGIT_W'(v);
            end
        end
        return {found, val};
    endfunction

    // Mask of the symbols 1..idx, which is what precedes cell idx after a restart.
    function automatic logic [MASK_W-1:0] prefix_mask(input int idx);
        logic [MASK_W-1:0] m;
        m = '0;
        for (int b = 1; b < MASK_W; b++)
        begin
            if (b <= idx)
            begin
                m[b] = 1'b1;
            end
        end
        return m;
    endfunction

endpackage
`default_nettype wire

/* rtl/kpg_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kpg_cell: one digit of the selection
// Holds one digit and the mask of the symbols used to its left. The mask is
// passed on to the right neighbor every cycle, so a refill moves one cell
// per cycle along the row.
// ----------------------------------------------------------------------------
module kpg_cell #(
    parameter int IDX = 0
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  kpg_pkg::kpg_cell_ctrl_t             ctrl,
    input  wire  [kpg_pkg::DIGIT_W-1:0]         n_eff,
    input  wire  [kpg_pkg::DIGIT_W-1:0]         k_eff,
    input  wire  [kpg_pkg::MASK_W-1:0]          mask_in,
    output logic [kpg_pkg::MASK_W-1:0]          mask_out,
    output kpg_pkg::kpg_cell_stat_t             stat
);

    localparam logic [kpg_pkg::DIGIT_W-1:0] DIGIT_RST = kpg_pkg::DIGIT_W'(IDX + 1);
    localparam logic [kpg_pkg::MASK_W-1:0]  MASK_RST  = kpg_pkg::prefix_mask(IDX);

    logic [kpg_pkg::DIGIT_W-1:0] digit_reg, digit_next;
    logic [kpg_pkg::MASK_W-1:0]  mask_reg, mask_next;
    logic [kpg_pkg::DIGIT_W:0]   pivot_res;
    logic [kpg_pkg::DIGIT_W:0]   fill_res;
    logic                        active;

    // Candidates: the next free symbol above this digit, and the smallest
    // free symbol given the neighbor's updated mask.
    assign pivot_res = kpg_pkg::next_free(mask_reg, digit_reg, n_eff);
    assign fill_res  = kpg_pkg::next_free(mask_in, '0, n_eff);
    assign active    = (k_eff > kpg_pkg::DIGIT_W'(IDX));

    // Mask handed to the right neighbor includes this digit.
    assign mask_out = mask_reg | (kpg_pkg::MASK_W'(1) << digit_reg);

    assign stat.can_inc = active && pivot_res[kpg_pkg::DIGIT_W];
    assign stat.digit   = digit_reg;

    // Next digit and mask.
    always_comb
    begin
        digit_next = digit_reg;
        mask_next  = mask_in;
        if (ctrl.restart)
        begin
            digit_next = DIGIT_RST;
            mask_next  = MASK_RST;
        end
        else if (ctrl.pivot_we)
        begin
            digit_next = pivot_res[kpg_pkg::DIGIT_W-1:0];
        end
        else if (ctrl.fill_we)
        begin
            digit_next = fill_res[kpg_pkg::DIGIT_W-1:0];
        end
    end

    // Digit and mask registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_reg <= DIGIT_RST;
            mask_reg  <= MASK_RST;
        end
        else
        begin
            digit_reg <= digit_next;
            mask_reg  <= mask_next;
        end
    end

endmodule
`default_nettype wire

/* rtl/kpg_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kpg_ctrl: sequencer for the k-permutation generator
// Holds the configuration registers, finds the rightmost digit that can be
// raised, steps the refill along the cell row and owns the output register.
// ----------------------------------------------------------------------------
module kpg_ctrl #(
    parameter int MAX_DIGITS = kpg_pkg::DEF_MAX_DIGITS
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 cfg_valid,
    output logic                                cfg_ready,
    input  wire  [kpg_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire  [kpg_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  wire                                 in_valid,
    output logic                                in_ready,
    input  wire                                 restart,
    output logic                                out_valid,
    input  wire                                 out_ready,
    output logic [kpg_pkg::SEL_W-1:0]           selection,
    output logic                                valid_res,
    output logic                                is_last,
    input  kpg_pkg::kpg_cell_stat_t             stat [MAX_DIGITS],
    output kpg_pkg::kpg_cell_ctrl_t             cell_ctrl [MAX_DIGITS],
    output logic [kpg_pkg::DIGIT_W-1:0]         n_eff,
    output logic [kpg_pkg::DIGIT_W-1:0]         k_eff
);

    localparam int IDX_W  = $clog2(MAX_DIGITS);
    localparam int PACK_N = (MAX_DIGITS < kpg_pkg::SEL_NIBBLES) ? MAX_DIGITS
                                                                : kpg_pkg::SEL_NIBBLES;

    kpg_pkg::kpg_state_t state_reg, state_next;

    logic [kpg_pkg::CFG_DATA_W-1:0] symbol_count_reg;
    logic [kpg_pkg::CFG_DATA_W-1:0] pick_count_reg;
    logic                           exhausted_reg, exhausted_next;
    logic [IDX_W-1:0]               fill_pos_reg, fill_pos_next;

    logic                           out_valid_reg;
    logic [kpg_pkg::SEL_W-1:0]      selection_reg, selection_next;
    logic                           valid_res_reg, valid_res_next;
    logic                           is_last_reg, is_last_next;

    logic                           cfg_wr;
    logic                           cfg_hit;
    logic                           in_acc;
    logic                           restart_all;
    logic                           out_free;
    logic                           load_out;
    logic                           pivot_go;
    logic [kpg_pkg::DIGIT_W-1:0]    k_raw;
    logic [kpg_pkg::DIGIT_W-1:0]    k_clip;
    logic [kpg_pkg::DIGIT_W-1:0]    k_last;
    logic [kpg_pkg::SEL_W-1:0]      packed_sel;
    logic                           any_inc;
    logic [IDX_W-1:0]               pivot_idx;

    // Handshakes.
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign cfg_hit   = cfg_wr && ((cfg_index == kpg_pkg::CFG_SYMBOL_COUNT) ||
                                  (cfg_index == kpg_pkg::CFG_PICK_COUNT));
    assign in_ready  = (state_reg == kpg_pkg::ST_IDLE);
    assign in_acc    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;

    // A restart request or any register write returns to the first selection.
    assign restart_all = (in_acc && restart) || cfg_hit;

    // Effective symbol and pick counts.
    assign n_eff  = (symbol_count_reg == '0) ? kpg_pkg::DIGIT_W'(1) : symbol_count_reg;
    assign k_raw  = (pick_count_reg == '0) ? kpg_pkg::DIGIT_W'(1) : pick_count_reg;
    assign k_clip = (k_raw > n_eff) ? n_eff : k_raw;
    assign k_eff  = (k_clip > kpg_pkg::DIGIT_W'(MAX_DIGITS)) ? kpg_pkg::DIGIT_W'(MAX_DIGITS)
                                                             : k_clip;
    assign k_last = k_eff - kpg_pkg::DIGIT_W'(1);

    // Pack the active digits, first digit in the lowest nibble.
    always_comb
    begin
        packed_sel = '0;
        for (int i = 0; i < PACK_N; i++)
        begin
            if (kpg_pkg::DIGIT_W'(i) < k_eff)
            begin
                packed_sel[kpg_pkg::DIGIT_W*i +: kpg_pkg::DIGIT_W] = stat[i].digit;
            end
        end
    end

    // Rightmost cell that can take a larger free symbol.
    always_comb
    begin
        any_inc   = 1'b0;
        pivot_idx = '0;
        for (int i = 0; i < MAX_DIGITS; i++)
        begin
            if (stat[i].can_inc)
            begin
                any_inc   = 1'b1;
                pivot_idx = IDX_W'(i);
            end
        end
    end

    // Next state, result and refill control.
    always_comb
    begin
        state_next     = state_reg;
        exhausted_next = exhausted_reg;
        fill_pos_next  = fill_pos_reg;
        load_out       = 1'b0;
        pivot_go       = 1'b0;
        selection_next = '0;
        valid_res_next = 1'b0;
        is_last_next   = 1'b0;
        case (state_reg)
            kpg_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = kpg_pkg::ST_SEARCH;
                end
            end
            kpg_pkg::ST_SEARCH:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = kpg_pkg::ST_IDLE;
                    if (!exhausted_reg)
                    begin
                        selection_next = packed_sel;
                        valid_res_next = 1'b1;
                        if (any_inc)
                        begin
                            pivot_go = 1'b1;
                            if (kpg_pkg::DIGIT_W'(pivot_idx) != k_last)
                            begin
                                state_next    = kpg_pkg::ST_FILL;
                                fill_pos_next = pivot_idx + IDX_W'(1);
                            end
                        end
                        else
                        begin
                            is_last_next   = 1'b1;
                            exhausted_next = 1'b1;
                        end
                    end
                end
            end
            kpg_pkg::ST_FILL:
            begin
                if (kpg_pkg::DIGIT_W'(fill_pos_reg) == k_last)
                begin
                    state_next = kpg_pkg::ST_IDLE;
                end
                else
                begin
                    fill_pos_next = fill_pos_reg + IDX_W'(1);
                end
            end
            default:
            begin
                state_next = kpg_pkg::ST_IDLE;
            end
        endcase
        if (restart_all)
        begin
            exhausted_next = 1'b0;
        end
    end

    // Cell write strobes: at most one pivot or fill write per cycle; restart reaches all cells.
    always_comb
    begin
        for (int i = 0; i < MAX_DIGITS; i++)
        begin
            cell_ctrl[i].restart  = restart_all;
            cell_ctrl[i].pivot_we = pivot_go && (pivot_idx == IDX_W'(i));
            cell_ctrl[i].fill_we  = (state_reg == kpg_pkg::ST_FILL) &&
                                    (fill_pos_reg == IDX_W'(i));
        end
    end

    // State, configuration and output valid registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= kpg_pkg::ST_IDLE;
            symbol_count_reg <= kpg_pkg::RST_SYMBOL_COUNT;
            pick_count_reg   <= kpg_pkg::RST_PICK_COUNT;
            exhausted_reg    <= 1'b0;
            fill_pos_reg     <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            exhausted_reg <= exhausted_next;
            fill_pos_reg  <= fill_pos_next;
            if (cfg_wr && (cfg_index == kpg_pkg::CFG_SYMBOL_COUNT))
            begin
                symbol_count_reg <= cfg_data;
            end
            if (cfg_wr && (cfg_index == kpg_pkg::CFG_PICK_COUNT))
            begin
                pick_count_reg <= cfg_data;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            selection_reg <= selection_next;
            valid_res_reg <= valid_res_next;
            is_last_reg   <= is_last_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign selection = selection_reg;
    assign valid_res = valid_res_reg;
    assign is_last   = is_last_reg;

endmodule
`default_nettype wire

/* rtl/k_permutation_generator.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// k_permutation_generator: lexicographic k-permutation enumerator
// Returns the ordered selections of pick_count distinct symbols out of
// 1..symbol_count, one per request, using a row of digit cells.
// ----------------------------------------------------------------------------
// Usage:
//   Each request on the input channel (in_valid/in_ready, field restart)
//   yields exactly one result on the output channel (out_valid/out_ready,
//   fields selection, valid_res, is_last). With restart high the enumeration
//   first returns to 1,2,...,k. After the final selection (is_last high)
//   every result has valid_res low and selection zero until a restart.
//   The configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data)
//   writes symbol_count (index 0) or pick_count (index 1); either write also
//   restarts the enumeration. Write it only while the block is idle.
// Timing:
//   The request is accepted in the idle state; the result is loaded into the
//   output register from the search state once that register is free. A
//   request then occupies the block through the search and then the refill
//   of any digits right of p, p being the position of the digit that was
//   raised; the refill moves along the cell row one cell per cycle.
//   A new request is taken while the previous result still waits in the
//   output register; if the receiver stalls, the block holds its next
//   result until the register frees. Reset restores symbol_count = 9,
//   pick_count = 3 and the first selection.
// ----------------------------------------------------------------------------
module k_permutation_generator #(
    parameter int MAX_DIGITS = kpg_pkg::DEF_MAX_DIGITS
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 cfg_valid,
    output logic                                cfg_ready,
    input  wire  [kpg_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire  [kpg_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  wire                                 in_valid,
    output logic                                in_ready,
    input  wire                                 restart,
    output logic                                out_valid,
    input  wire                                 out_ready,
    output logic [kpg_pkg::SEL_W-1:0]           selection,
    output logic                                valid_res,
    output logic                                is_last
);

    kpg_pkg::kpg_cell_stat_t     stat      [MAX_DIGITS];
    kpg_pkg::kpg_cell_ctrl_t     cell_ctrl [MAX_DIGITS];
    logic [kpg_pkg::MASK_W-1:0]  mask_link [MAX_DIGITS+1];
    logic [kpg_pkg::DIGIT_W-1:0] n_eff;
    logic [kpg_pkg::DIGIT_W-1:0] k_eff;

    // Sequencer.
    kpg_ctrl #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .restart    (restart),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .selection  (selection),
        .valid_res  (valid_res),
        .is_last    (is_last),
        .stat       (stat),
        .cell_ctrl  (cell_ctrl),
        .n_eff      (n_eff),
        .k_eff      (k_eff)
    );

    // Row of digit cells; the used-symbol mask runs left to right.
    assign mask_link[0] = '0;

    for (genvar i = 0; i < MAX_DIGITS; i++)
    begin : g_cell
        kpg_cell #(
            .IDX (i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (cell_ctrl[i]),
            .n_eff    (n_eff),
            .k_eff    (k_eff),
            .mask_in  (mask_link[i]),
            .mask_out (mask_link[i+1]),
            .stat     (stat[i])
        );
    end

`ifndef SYNTHESIS
    // An exhausted result carries no selection and no last flag.
    a_exhausted_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !valid_res |-> (selection == '0) && !is_last)
    else $error("exhausted result carries data");

    // The last selection is always a valid one.
    a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_last |-> valid_res)
    else $error("last flag on an invalid result");

    // The block is busy in the cycle after it takes a request.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
    else $error("request taken while still searching");
`endif

endmodule
`default_nettype wire
